>>> design/mrcf_pkg.sv
// ----------------------------------------------------------------------------
// mrcf_pkg
// Shared types, constants and pointer helpers for the mouse report
// coalescing fifo.
// ----------------------------------------------------------------------------
package mrcf_pkg;

	localparam int RING_DEPTH = 8;
	localparam int SUM_WIDTH  = 16;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic STATUS_ENTRY = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic [7:0]                  buttons;
		logic signed [SUM_WIDTH-1:0] sum_x;
		logic signed [SUM_WIDTH-1:0] sum_y;
	} entry_t;

	typedef struct packed {
		logic   en;
		ptr_t   addr;
		entry_t data;
	} ring_wr_t;

	typedef enum logic {
		S_IDLE,
		S_LOOKUP
	} state_t;

	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		r = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
		return r;
	endfunction

	function automatic ptr_t ptr_prev(input ptr_t p);
		ptr_t r;
		r = (p == '0) ? PTR_W'(RING_DEPTH - 1) : ptr_t'(p - 1'b1);
		return r;
	endfunction

endpackage

>>> design/mrcf_ring.sv
// ----------------------------------------------------------------------------
// mrcf_ring
// Entry storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mrcf_ring (
	input  logic              clk,
	input  mrcf_pkg::ring_wr_t wr,
	input  mrcf_pkg::ptr_t     rd_addr,
	output mrcf_pkg::entry_t   rd_data
);
	import mrcf_pkg::*;

	entry_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/mouse_report_coalescing_fifo_top.sv
// ----------------------------------------------------------------------------
// mouse_report_coalescing_fifo_top
// Buffers mouse reports in a ring, folding motion of reports with equal
// buttons into the newest entry; read commands pop the oldest entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a command plus one report.
//   A report transfer produces no result; a read transfer produces exactly
//   one result on the output channel (out_valid / out_stall): the oldest
//   entry with status 0, or status 1 and zero payload when the ring is empty.
//   Each transfer has an accept and a lookup step: the accept cycle issues
//   the ring read (newest entry for a report, oldest for a read) and the
//   lookup step, in the next cycle, uses the registered read data to merge,
//   append or pop. in_stall is high during the lookup step, so a new item is
//   taken only once the last is done. A read result is loaded into the
//   output register as the lookup step ends. If the output register still
//   holds an untaken result, a read stays in its lookup step until it
//   drains; reports finish regardless.
//   Reset clears the pointers, the last-report register and the output
//   valid flag; the ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module mouse_report_coalescing_fifo_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [7:0]                           button_bits,
	input  logic signed [7:0]                    delta_x,
	input  logic signed [7:0]                    delta_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 status,
	output logic [7:0]                           out_buttons,
	output logic signed [mrcf_pkg::SUM_WIDTH-1:0] sum_x,
	output logic signed [mrcf_pkg::SUM_WIDTH-1:0] sum_y
);
	import mrcf_pkg::*;

	state_t state_q, state_d;

	ptr_t wr_ptr_q, rd_ptr_q;
	logic [23:0] last_report_q;

	logic              cmd_q;
	logic [7:0]        btn_q;
	logic signed [7:0] dx_q, dy_q;

	logic                        out_valid_q;
	logic                        status_q;
	logic [7:0]                  out_buttons_q;
	logic signed [SUM_WIDTH-1:0] sum_x_q, sum_y_q;

	ring_wr_t ring_wr;
	ptr_t     ring_rd_addr;
	entry_t   ring_rd_data;

	logic load_item, out_free, result_load, report_do, merge, append;
	logic empty, full, addr_cmd;
	logic [23:0] packed_q;
	logic signed [SUM_WIDTH-1:0] dx_ext, dy_ext;

	mrcf_ring u_ring (
		.clk     (clk),
		.wr      (ring_wr),
		.rd_addr (ring_rd_addr),
		.rd_data (ring_rd_data)
	);

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (ptr_next(wr_ptr_q) == rd_ptr_q);
	assign out_free = !out_valid_q || !out_stall;
	assign packed_q = {dy_q, dx_q, btn_q};
	assign dx_ext   = SUM_WIDTH'(dx_q);
	assign dy_ext   = SUM_WIDTH'(dy_q);

	// read address follows the incoming command while idle, the held one after
	assign addr_cmd     = (state_q == S_IDLE) ? command : cmd_q;
	assign ring_rd_addr = (addr_cmd == CMD_READ) ? rd_ptr_q : ptr_prev(wr_ptr_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (cmd_q == CMD_REPORT || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall    = 1'b1;
		load_item   = 1'b0;
		result_load = 1'b0;
		report_do   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				load_item = in_valid;
			end
			S_LOOKUP: begin
				result_load = (cmd_q == CMD_READ) && out_free;
				report_do   = (cmd_q == CMD_REPORT) && (packed_q != last_report_q);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign merge  = report_do && !empty && (ring_rd_data.buttons == btn_q);
	assign append = report_do && !merge && !full;

	always_comb begin
		ring_wr.en           = merge || append;
		ring_wr.addr         = merge ? ptr_prev(wr_ptr_q) : wr_ptr_q;
		ring_wr.data.buttons = btn_q;
		if (merge) begin
			ring_wr.data.sum_x = ring_rd_data.sum_x + dx_ext;
			ring_wr.data.sum_y = ring_rd_data.sum_y + dy_ext;
		end else begin
			ring_wr.data.sum_x = dx_ext;
			ring_wr.data.sum_y = dy_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			last_report_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (append) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (report_do) begin
				last_report_q <= packed_q;
			end
			if (result_load) begin
				out_valid_q <= 1'b1;
				if (!empty) begin
					rd_ptr_q <= ptr_next(rd_ptr_q);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (load_item) begin
			cmd_q <= command;
			btn_q <= button_bits;
			dx_q  <= delta_x;
			dy_q  <= delta_y;
		end
		if (result_load) begin
			if (empty) begin
				status_q      <= STATUS_EMPTY;
				out_buttons_q <= '0;
				sum_x_q       <= '0;
				sum_y_q       <= '0;
			end else begin
				status_q      <= STATUS_ENTRY;
				out_buttons_q <= ring_rd_data.buttons;
				sum_x_q       <= ring_rd_data.sum_x;
				sum_y_q       <= ring_rd_data.sum_y;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_buttons = out_buttons_q;
	assign sum_x       = sum_x_q;
	assign sum_y       = sum_y_q;

endmodule
